// File: src/ndt_pkg.sv
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types, constants and helpers for the name keyed directory table.
// ----------------------------------------------------------------------------
package ndt_pkg;

  localparam int ENTRIES     = 16;
  localparam int NAME_BYTES  = 8;
  localparam int SECTOR_BITS = 10;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_name;
    logic [9:0]  sector_number;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] entry_index;
    logic [9:0] entry_sector;
    logic [4:0] used_count;
  } rsp_t;

  // One directory entry as held in the entry RAM.
  typedef struct packed {
    logic [63:0]            name;
    logic [SECTOR_BITS-1:0] sector;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Entry RAM access from the controller.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_cmd_t;

  // Keep bytes up to the first NUL within NAME_BYTES; clear the rest.
  function automatic logic [63:0] normalize(input logic [63:0] name);
    logic [63:0] out;
    logic        alive;
    out   = '0;
    alive = 1'b1;
    for (int pos = 0; pos < 8; pos++) begin
      if (pos >= NAME_BYTES || name[8*pos +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        out[8*pos +: 8] = name[8*pos +: 8];
      end
    end
    return out;
  endfunction

endpackage

// File: src/ndt_ram.sv
// ----------------------------------------------------------------------------
// ndt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ndt_ctrl.sv
// ----------------------------------------------------------------------------
// ndt_ctrl
// Scan sequencer: walks the entry RAM once per transaction, matches the key,
// finds the first free entry, then commits the update and issues the result.
// ----------------------------------------------------------------------------
module ndt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ndt_pkg::req_t     req,
  output logic              busy,
  output logic              done,
  output ndt_pkg::rsp_t     rsp,
  output ndt_pkg::ram_cmd_t ram_cmd,
  input  ndt_pkg::entry_t   ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic [ndt_pkg::ENTRIES-1:0]     valid;
  logic [ndt_pkg::CNT_W-1:0]       used;
  logic [ndt_pkg::CNT_W-1:0]       cnt;
  logic                            chk;
  logic [ndt_pkg::IDX_W-1:0]       chk_idx;

  logic [1:0]                      op_type;
  logic [63:0]                     op_key;
  logic [ndt_pkg::SECTOR_BITS-1:0] op_sector;

  logic                            hit;
  logic [ndt_pkg::IDX_W-1:0]       hit_idx;
  logic [ndt_pkg::SECTOR_BITS-1:0] hit_sector;
  logic                            free_found;
  logic [ndt_pkg::IDX_W-1:0]       free_idx;

  logic                            scan_more;
  logic                            match;

  // FINISH-cycle decisions
  logic                            add_ok;
  logic                            rem_ok;
  logic [1:0]                      status_next;
  logic [ndt_pkg::IDX_W-1:0]       index_next;
  logic [ndt_pkg::SECTOR_BITS-1:0] sector_next;
  logic [ndt_pkg::CNT_W-1:0]       used_next;

  assign busy      = (state != S_IDLE);
  assign scan_more = (cnt < ndt_pkg::CNT_W'(ndt_pkg::ENTRIES));
  assign match     = chk && valid[chk_idx] && (ram_rdata.name == op_key);

  always_comb begin
    add_ok      = 1'b0;
    rem_ok      = 1'b0;
    status_next = ndt_pkg::ST_NOT_FOUND;
    index_next  = '0;
    sector_next = '0;
    case (op_type)
      ndt_pkg::REQ_ADD: begin
        if (hit) begin
          status_next = ndt_pkg::ST_PRESENT;
        end else if (free_found) begin
          add_ok      = 1'b1;
          status_next = ndt_pkg::ST_OK;
          index_next  = free_idx;
        end else begin
          status_next = ndt_pkg::ST_FULL;
        end
      end
      ndt_pkg::REQ_REMOVE: begin
        if (hit) begin
          rem_ok      = 1'b1;
          status_next = ndt_pkg::ST_OK;
          index_next  = hit_idx;
        end
      end
      default: begin
        // find, and the unused code, which behaves as find
        if (hit) begin
          status_next = ndt_pkg::ST_OK;
          index_next  = hit_idx;
          sector_next = hit_sector;
        end
      end
    endcase
    if (add_ok) begin
      used_next = used + ndt_pkg::CNT_W'(1);
    end else if (rem_ok) begin
      used_next = used - ndt_pkg::CNT_W'(1);
    end else begin
      used_next = used;
    end
  end

  always_comb begin
    ram_cmd.we           = (state == S_FINISH) && add_ok;
    ram_cmd.waddr        = free_idx;
    ram_cmd.wdata.name   = op_key;
    ram_cmd.wdata.sector = op_sector;
    ram_cmd.raddr        = cnt[ndt_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      used       <= '0;
      cnt        <= '0;
      chk        <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_type    <= req.req_type;
            op_key     <= ndt_pkg::normalize(req.key_name);
            op_sector  <= ndt_pkg::SECTOR_BITS'(req.sector_number);
            cnt        <= '0;
            chk        <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read issued at cnt, compared in the following cycle at chk_idx
          chk     <= scan_more;
          chk_idx <= cnt[ndt_pkg::IDX_W-1:0];
          if (scan_more) begin
            cnt <= cnt + ndt_pkg::CNT_W'(1);
          end
          if (match && !hit) begin
            hit        <= 1'b1;
            hit_idx    <= chk_idx;
            hit_sector <= ram_rdata.sector;
          end
          if (chk && !valid[chk_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (!scan_more && !chk) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (add_ok) begin
            valid[free_idx] <= 1'b1;
          end
          if (rem_ok) begin
            valid[hit_idx] <= 1'b0;
          end
          used             <= used_next;
          rsp.status       <= status_next;
          rsp.entry_index  <= 4'(index_next);
          rsp.entry_sector <= 10'(sector_next);
          rsp.used_count   <= 5'(used_next);
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/name_keyed_directory_table.sv
// ----------------------------------------------------------------------------
// name_keyed_directory_table
// Fixed directory table: find, add and remove entries keyed by a NUL-padded
// name. Names and sectors live in one entry RAM; valid marks in flops.
//
//   channel   signals              transfer
//   request   start, busy, req     taken when start && !busy
//   result    done, rsp            done high for one cycle, no backpressure
//
// Each transaction scans the table with one RAM read per entry through the
// single read port, drains the read pipeline, then commits the update in the
// FINISH state and raises done. A new request may be accepted in the cycle done is high.
// Reset clears the valid marks and the used count; RAM contents stay as is.
// ----------------------------------------------------------------------------
module name_keyed_directory_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ndt_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output ndt_pkg::rsp_t rsp
);

  ndt_pkg::ram_cmd_t ram_cmd;
  ndt_pkg::entry_t   ram_rdata;

  ndt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .ram_cmd   (ram_cmd),
    .ram_rdata (ram_rdata)
  );

  ndt_ram #(
    .WIDTH (ndt_pkg::ENTRY_W),
    .DEPTH (ndt_pkg::ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: src/ndt_checker.sv
// ----------------------------------------------------------------------------
// ndt_checker
// Port-level checks on the directory table, bound to the top level.
// ----------------------------------------------------------------------------
module ndt_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ndt_pkg::rsp_t rsp
);

  // accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // result only at the end of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside end of transaction");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.used_count <= 5'(ndt_pkg::ENTRIES)))
    else $error("used count beyond table size");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ndt_pkg::ST_OK) |->
      (rsp.entry_index == 4'd0 && rsp.entry_sector == 10'd0))
    else $error("failed transaction reported index or sector");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ndt_pkg::ST_FULL) |->
      (rsp.used_count == 5'(ndt_pkg::ENTRIES)))
    else $error("table full with free entries");

endmodule

bind name_keyed_directory_table ndt_checker u_ndt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
